### hdl/spr_pkg.sv
`default_nettype none
package spr_pkg;
    localparam int TAPS = 8;
    localparam int PHASE_BITS = 5;
    localparam int FRAC_BITS = 15;
    localparam int ROWS = (1 << PHASE_BITS) + 1;
    localparam int STORE_DEPTH = ROWS * TAPS;
    localparam int MAX_OUT = 64;
    localparam int PHASE_W = 37;
    localparam int START_W = 32;
    localparam logic [36:0] RESET_INC = 37'h1_0000_0000;

    localparam logic [0:0] REG_PHASE_INC = 1'b0;
    localparam logic [0:0] REG_START_PHASE = 1'b1;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic [8:0]         coef_address;
        logic signed [15:0] coef_value;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic               last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [0:0]  index;
        logic [63:0] data;
    } cfg_item_t;

    function automatic logic signed [15:0] sat16(input logic signed [35:0] acc);
        logic signed [35:0] r;
        begin
            r = (acc + 36'sd8192) >>> 14;
            if (r > 36'sd32767)
                sat16 = 16'sh7FFF;
            else if (r < -36'sd32768)
                sat16 = 16'sh8000;
            else
                sat16 = r[15:0];
        end
    endfunction
endpackage
`default_nettype wire

### hdl/spr_ram.sv
`default_nettype none
module spr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 264
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

### hdl/spr_mac.sv
`default_nettype none
// Interpolates one coefficient per cycle and accumulates both channels.
module spr_mac (
    input  wire logic               clk,
    input  wire logic               clear,
    input  wire logic               valid,
    input  wire logic signed [15:0] c0,
    input  wire logic signed [15:0] c1,
    input  wire logic [14:0]        frac,
    input  wire logic signed [15:0] hist_l,
    input  wire logic signed [15:0] hist_r,
    output logic signed [35:0]      acc_l,
    output logic signed [35:0]      acc_r
);
    logic signed [15:0] diff;
    logic signed [31:0] prod;
    logic signed [15:0] coef;
    logic signed [15:0] coef_reg;
    logic signed [15:0] hl_reg;
    logic signed [15:0] hr_reg;
    logic               valid_reg;
    logic signed [31:0] prod_l;
    logic signed [31:0] prod_r;

    always_comb
    begin
        diff = c1 - c0;
        prod = diff * $signed({1'b0, frac});
        coef = c0 + {prod[30:16], 1'b0};
        prod_l = hl_reg * coef_reg;
        prod_r = hr_reg * coef_reg;
    end

    always_ff @(posedge clk)
    begin
        coef_reg  <= coef;
        hl_reg    <= hist_l;
        hr_reg    <= hist_r;
        valid_reg <= valid;
        if (clear)
        begin
            acc_l <= '0;
            acc_r <= '0;
        end
        else if (valid_reg)
        begin
            acc_l <= acc_l + 36'(prod_l);
            acc_r <= acc_r + 36'(prod_r);
        end
    end
endmodule
`default_nettype wire

### hdl/stereo_polyphase_resampler_unit.sv
`default_nettype none
// Sample push with a full window: each output passes through a check state, two coefficient
// reads per tap (RD0, RD1) through the single memory read port, the MAC drain states and
// the output transfer, which waits for out_ready; the input is freed once a check finds
// no further output for the push.
// Coefficient writes and pushes that only fill the window leave the unit in idle.
// Reset clears history and fill count, loads phase with 0 and the increment with one
// sample; the coefficient memory is not cleared and must be written before use.
module stereo_polyphase_resampler_unit #(
    parameter int TAPS = spr_pkg::TAPS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire spr_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output spr_pkg::out_item_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire spr_pkg::cfg_item_t cfg_data
);
    localparam int TW = $clog2(TAPS);
    localparam int AW = $clog2(spr_pkg::STORE_DEPTH);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_RD0 = 3'd2;
    localparam logic [2:0] S_RD1 = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;

    logic [2:0]  state_reg;
    logic [36:0] inc_reg;
    logic [36:0] phase_reg;
    logic [3:0]  fill_reg;
    logic [6:0]  count_reg;
    logic [TW-1:0] tap_reg;
    logic signed [15:0] hl_reg [TAPS];
    logic signed [15:0] hr_reg [TAPS];
    logic signed [15:0] c0_reg;
    logic [3:0]  drain_reg;
    logic        mac_valid;
    logic        mac_clear;
    logic [AW-1:0] rd_addr;
    logic [15:0] rd_data;
    logic [TW-1:0] tap_d_reg;
    logic signed [35:0] acc_l;
    logic signed [35:0] acc_r;
    logic        wr_en;
    logic [37:0] phase_sum;
    logic [36:0] phase_adv;
    logic [AW-1:0] row_base;
    logic        mac_go_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign wr_en = in_valid && in_ready && (in_data.req_type == spr_pkg::REQ_COEF)
        && (in_data.coef_address < 9'(spr_pkg::STORE_DEPTH));

    assign row_base = AW'({4'd0, phase_reg[31:27]} * TAPS);
    assign phase_sum = {1'b0, phase_reg} + {1'b0, inc_reg};
    assign phase_adv = phase_sum[37] ? '1 : phase_sum[36:0];

    always_comb
    begin
        if (state_reg == S_RD0)
            rd_addr = row_base + AW'(tap_reg);
        else
            rd_addr = row_base + AW'(TAPS) + AW'(tap_reg);
    end

    spr_ram #(.WIDTH(16), .DEPTH(spr_pkg::STORE_DEPTH)) u_coef (
        .clk(clk), .wr_en(wr_en), .wr_addr(in_data.coef_address[AW-1:0]),
        .wr_data(in_data.coef_value), .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // RD0 reads c0, RD1 reads c1 while c0 returns; c1 is consumed in the next RD0 (DRAIN after the last tap).
    assign mac_valid = mac_go_reg && (state_reg == S_RD0 || state_reg == S_DRAIN);
    assign mac_clear = (state_reg == S_CHECK);

    spr_mac u_mac (
        .clk(clk), .clear(mac_clear), .valid(mac_valid), .c0(c0_reg),
        .c1(rd_data), .frac(phase_reg[26:12]), .hist_l(hl_reg[tap_d_reg]),
        .hist_r(hr_reg[tap_d_reg]), .acc_l(acc_l), .acc_r(acc_r)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD1)
            tap_d_reg <= tap_reg;
        if (state_reg == S_RD1)
            c0_reg <= rd_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            inc_reg   <= spr_pkg::RESET_INC;
            phase_reg <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
            tap_reg   <= '0;
            drain_reg <= '0;
            mac_go_reg <= 1'b0;
            out_valid <= 1'b0;
            out_data  <= '0;
            for (int i = 0; i < TAPS; i++)
            begin
                hl_reg[i] <= '0;
                hr_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data.index == spr_pkg::REG_PHASE_INC)
                    inc_reg <= cfg_data.data[36:0];
                else
                    phase_reg <= {5'd0, cfg_data.data[31:0]};
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_data.req_type == spr_pkg::REQ_SAMPLE)
                    begin
                        for (int i = 0; i < TAPS - 1; i++)
                        begin
                            hl_reg[i] <= hl_reg[i+1];
                            hr_reg[i] <= hr_reg[i+1];
                        end
                        hl_reg[TAPS-1] <= in_data.left_sample;
                        hr_reg[TAPS-1] <= in_data.right_sample;
                        count_reg <= '0;
                        if (fill_reg != 4'(TAPS))
                            fill_reg <= fill_reg + 4'd1;
                        if (fill_reg >= 4'(TAPS - 1))
                            state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    tap_reg <= '0;
                    mac_go_reg <= 1'b0;
                    if (phase_reg[36:32] == 5'd0 && count_reg != 7'(spr_pkg::MAX_OUT))
                        state_reg <= S_RD0;
                    else
                    begin
                        if (phase_reg[36:32] != 5'd0)
                            phase_reg <= phase_reg - 37'h1_0000_0000;
                        state_reg <= S_IDLE;
                    end
                end
                S_RD0:
                    state_reg <= S_RD1;
                S_RD1:
                begin
                    mac_go_reg <= 1'b1;
                    if (tap_reg == TW'(TAPS - 1))
                    begin
                        state_reg <= S_DRAIN;
                        drain_reg <= '0;
                    end
                    else
                    begin
                        tap_reg <= tap_reg + 1'b1;
                        state_reg <= S_RD0;
                    end
                end
                S_DRAIN:
                begin
                    mac_go_reg <= 1'b0;
                    drain_reg <= drain_reg + 4'd1;
                    if (drain_reg == 4'd2)
                    begin
                        out_valid <= 1'b1;
                        out_data.out_left <= spr_pkg::sat16(acc_l);
                        out_data.out_right <= spr_pkg::sat16(acc_r);
                        out_data.last_of_run <= (phase_adv[36:32] != 5'd0)
                            || (count_reg == 7'(spr_pkg::MAX_OUT - 1));
                        phase_reg <= phase_adv;
                        count_reg <= count_reg + 7'd1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_CHECK;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
